@@ rtl/ifd_pkg.sv @@
// Shared types, widths and constants for the fall detector.
// Used by every module of the block and by its checker; depends on nothing.
`default_nettype none

package ifd_pkg;

  localparam int FRAC_BITS   = 8;
  localparam int AXIS_W      = 16;
  localparam int ABS_W       = AXIS_W + 1;
  localparam int SQ_W        = 32;
  localparam int MAG_W       = SQ_W / 2;
  localparam int S_W         = MAG_W + FRAC_BITS;
  localparam int LEVEL_W     = 16;
  localparam int TIME_W      = 32;
  localparam int CNT_W       = 16;
  localparam int W_W         = 9;
  localparam int W_SHIFT     = 8;
  localparam int W_ONE       = 1 << W_SHIFT;
  localparam int W_ROUND     = 1 << (W_SHIFT - 1);
  localparam int PROD_W      = W_W + S_W;
  localparam int OUT_MAG_W   = 24;
  localparam int NUM_AXES    = 3;
  localparam int AXIS_IDX_W  = $clog2(NUM_AXES);
  localparam int ROOT_STEPS  = SQ_W / 2;
  localparam int ROOT_CNT_W  = $clog2(ROOT_STEPS);
  localparam int FIFO_DEPTH  = 2;
  localparam int FIFO_PTR_W  = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
  localparam int FIFO_CNT_W  = $clog2(FIFO_DEPTH + 1);
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;

  localparam int IN_FIELDS_W  = 3 * AXIS_W + TIME_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 + OUT_MAG_W + 1 + 2 * CNT_W;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_PAD_W    = OUT_TDATA_W - OUT_FIELDS_W;

  localparam logic [W_W-1:0]     RST_EMA_WEIGHT  = W_W'(77);
  localparam logic [LEVEL_W-1:0] RST_FREE_FALL   = LEVEL_W'(500);
  localparam logic [LEVEL_W-1:0] RST_IMPACT      = LEVEL_W'(3000);
  localparam logic [LEVEL_W-1:0] RST_RECOVER     = LEVEL_W'(800);
  localparam logic [LEVEL_W-1:0] RST_STILL_UPPER = LEVEL_W'(1200);
  localparam logic [TIME_W-1:0]  RST_STILL_TIME  = TIME_W'(1000);

  typedef enum logic [1:0] {
    PH_NORMAL    = 2'd0,
    PH_FREE_FALL = 2'd1,
    PH_IMPACT    = 2'd2,
    PH_FALL      = 2'd3
  } phase_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_EMA_WEIGHT  = 3'd0,
    REG_FREE_FALL   = 3'd1,
    REG_IMPACT      = 3'd2,
    REG_RECOVER     = 3'd3,
    REG_STILL_UPPER = 3'd4,
    REG_STILL_TIME  = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [W_W-1:0]     ema_weight;
    logic [LEVEL_W-1:0] free_fall_level;
    logic [LEVEL_W-1:0] impact_level;
    logic [LEVEL_W-1:0] recover_level;
    logic [LEVEL_W-1:0] still_upper_level;
    logic [TIME_W-1:0]  still_time;
  } cfg_t;

  typedef struct packed {
    logic [TIME_W-1:0]        sample_time;
    logic signed [AXIS_W-1:0] accel_z;
    logic signed [AXIS_W-1:0] accel_y;
    logic signed [AXIS_W-1:0] accel_x;
  } in_beat_t;

  typedef struct packed {
    logic [OUT_PAD_W-1:0] pad;
    logic [CNT_W-1:0]     fall_total;
    logic [CNT_W-1:0]     impact_total;
    logic                 state_changed;
    logic [OUT_MAG_W-1:0] filtered_magnitude;
    phase_t               motion_state;
  } out_beat_t;

  typedef struct packed {
    logic [MAG_W-1:0]  mag;
    logic [TIME_W-1:0] stamp;
  } mag_item_t;

  function automatic logic [ABS_W-1:0] abs_axis(input logic [AXIS_W-1:0] v);
    logic [ABS_W-1:0] e;
    e = {v[AXIS_W-1], v};
    return v[AXIS_W-1] ? (~e + ABS_W'(1)) : e;
  endfunction

  function automatic logic [S_W-1:0] level_q(input logic [LEVEL_W-1:0] l);
    return S_W'({l, {FRAC_BITS{1'b0}}});
  endfunction

endpackage

`default_nettype wire

@@ rtl/ifd_front.sv @@
// Front part: accepts a sample beat and forms the integer square-root magnitude.
// Uses ifd_pkg; one shared multiplier for the squares, one root bit per cycle.
`default_nettype none

module ifd_front import ifd_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_tvalid,
  output logic                       in_tready,
  input  wire logic [IN_TDATA_W-1:0] in_tdata,
  output logic                       push_valid,
  input  wire logic                  push_ready,
  output mag_item_t                  push_item
);

  typedef enum logic [3:0] {
    F_IDLE = 4'b0001,
    F_SQ   = 4'b0010,
    F_ROOT = 4'b0100,
    F_PUSH = 4'b1000
  } front_state_t;

  front_state_t           state_r, state_nxt;
  logic [AXIS_IDX_W-1:0]  idx_r, idx_nxt;
  logic [ROOT_CNT_W-1:0]  step_r, step_nxt;
  logic [ABS_W-1:0]       abs_r [NUM_AXES];
  logic [TIME_W-1:0]      stamp_r;
  logic [SQ_W-1:0]        n_r, n_nxt;
  logic [SQ_W-1:0]        root_r, root_nxt;
  logic [SQ_W-1:0]        bit_r, bit_nxt;
  logic [SQ_W-1:0]        square;
  logic [SQ_W-1:0]        trial;
  in_beat_t               beat;

  assign beat       = in_beat_t'(in_tdata[IN_FIELDS_W-1:0]);
  assign in_tready  = (state_r == F_IDLE);
  assign push_valid = (state_r == F_PUSH);
  assign push_item  = '{mag: root_r[MAG_W-1:0], stamp: stamp_r};
  assign square     = SQ_W'(abs_r[idx_r] * abs_r[idx_r]);
  assign trial      = root_r + bit_r;

  always_comb begin
    state_nxt = state_r;
    idx_nxt   = idx_r;
    step_nxt  = step_r;
    n_nxt     = n_r;
    root_nxt  = root_r;
    bit_nxt   = bit_r;
    unique case (state_r)
      F_IDLE: begin
        if (in_tvalid) begin
          state_nxt = F_SQ;
          idx_nxt   = '0;
          n_nxt     = '0;
        end
      end
      F_SQ: begin
        n_nxt = n_r + square;
        if (idx_r == AXIS_IDX_W'(NUM_AXES - 1)) begin
          state_nxt = F_ROOT;
          root_nxt  = '0;
          bit_nxt   = SQ_W'(1) << (SQ_W - 2);
          step_nxt  = '0;
        end else begin
          idx_nxt = idx_r + AXIS_IDX_W'(1);
        end
      end
      F_ROOT: begin
        if (n_r >= trial) begin
          n_nxt    = n_r - trial;
          root_nxt = (root_r >> 1) + bit_r;
        end else begin
          root_nxt = root_r >> 1;
        end
        bit_nxt  = bit_r >> 2;
        step_nxt = step_r + ROOT_CNT_W'(1);
        if (step_r == ROOT_CNT_W'(ROOT_STEPS - 1)) begin
          state_nxt = F_PUSH;
        end
      end
      F_PUSH: begin
        if (push_ready) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r  <= idx_nxt;
    step_r <= step_nxt;
    n_r    <= n_nxt;
    root_r <= root_nxt;
    bit_r  <= bit_nxt;
    if (in_tvalid && in_tready) begin
      abs_r[0] <= abs_axis(beat.accel_x);
      abs_r[1] <= abs_axis(beat.accel_y);
      abs_r[2] <= abs_axis(beat.accel_z);
      stamp_r  <= beat.sample_time;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ifd_fifo.sv @@
// Short queue of magnitudes and timestamps between the front and back parts.
// Uses ifd_pkg for the entry type and depth.
`default_nettype none

module ifd_fifo import ifd_pkg::*; (
  input  wire logic  clk,
  input  wire logic  rst_n,
  input  wire logic  wr_valid,
  output logic       wr_ready,
  input  mag_item_t  wr_item,
  output logic       rd_valid,
  input  wire logic  rd_ready,
  output mag_item_t  rd_item
);

  mag_item_t             mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [FIFO_CNT_W-1:0] count_r;
  logic                  do_wr, do_rd;

  assign wr_ready = (count_r != FIFO_CNT_W'(FIFO_DEPTH));
  assign rd_valid = (count_r != '0);
  assign rd_item  = mem_r[rd_ptr_r];
  assign do_wr    = wr_valid && wr_ready;
  assign do_rd    = rd_valid && rd_ready;

  function automatic logic [FIFO_PTR_W-1:0] ptr_inc(input logic [FIFO_PTR_W-1:0] p);
    return (p == FIFO_PTR_W'(FIFO_DEPTH - 1)) ? '0 : p + FIFO_PTR_W'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_r <= ptr_inc(wr_ptr_r);
      end
      if (do_rd) begin
        rd_ptr_r <= ptr_inc(rd_ptr_r);
      end
      if (do_wr && !do_rd) begin
        count_r <= count_r + FIFO_CNT_W'(1);
      end else if (do_rd && !do_wr) begin
        count_r <= count_r - FIFO_CNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wr_ptr_r] <= wr_item;
    end
  end

endmodule

`default_nettype wire

@@ rtl/ifd_back.sv @@
// Back part: exponential average of the magnitude, motion state machine,
// event counters and the result register. Uses ifd_pkg.
`default_nettype none

module ifd_back import ifd_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  cfg_t                        cfg,
  input  wire logic                   rd_valid,
  output logic                        rd_ready,
  input  mag_item_t                   rd_item,
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata
);

  typedef enum logic [4:0] {
    B_IDLE   = 5'b00001,
    B_MULA   = 5'b00010,
    B_MULB   = 5'b00100,
    B_SUM    = 5'b01000,
    B_DECIDE = 5'b10000
  } back_state_t;

  back_state_t         state_r, state_nxt;
  logic [MAG_W-1:0]    mag_r;
  logic [TIME_W-1:0]   stamp_r;
  logic [W_W-1:0]      w_r;
  logic [PROD_W-1:0]   prod_a_r, prod_b_r;
  logic [PROD_W:0]     sum;
  logic [S_W-1:0]      magq;
  logic [S_W-1:0]      s_r;
  logic                primed_r;
  phase_t              phase_r, phase_nxt;
  logic [TIME_W-1:0]   start_r, start_nxt;
  logic [CNT_W-1:0]    impacts_r, impacts_nxt;
  logic [CNT_W-1:0]    falls_r, falls_nxt;
  logic [TIME_W-1:0]   elapsed;
  logic                out_valid_r;
  out_beat_t           out_data_r;
  logic                commit;

  assign rd_ready   = (state_r == B_IDLE);
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign magq       = {mag_r, {FRAC_BITS{1'b0}}};
  assign sum        = (PROD_W + 1)'(prod_a_r) + (PROD_W + 1)'(prod_b_r)
                      + (PROD_W + 1)'(W_ROUND);
  assign elapsed    = stamp_r - start_r;
  assign commit     = (state_r == B_DECIDE) && (!out_valid_r || out_tready);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      B_IDLE:   if (rd_valid) state_nxt = B_MULA;
      B_MULA:   state_nxt = B_MULB;
      B_MULB:   state_nxt = B_SUM;
      B_SUM:    state_nxt = B_DECIDE;
      B_DECIDE: if (commit) state_nxt = B_IDLE;
      default:  state_nxt = B_IDLE;
    endcase
  end

  always_comb begin
    phase_nxt   = phase_r;
    start_nxt   = start_r;
    impacts_nxt = impacts_r;
    falls_nxt   = falls_r;
    case (phase_r)
      PH_NORMAL: begin
        if (s_r < level_q(cfg.free_fall_level)) begin
          phase_nxt = PH_FREE_FALL;
          start_nxt = stamp_r;
        end
      end
      PH_FREE_FALL: begin
        if (s_r > level_q(cfg.impact_level)) begin
          phase_nxt   = PH_IMPACT;
          start_nxt   = stamp_r;
          impacts_nxt = impacts_r + CNT_W'(1);
        end else if (s_r > level_q(cfg.recover_level)) begin
          phase_nxt = PH_NORMAL;
        end
      end
      PH_IMPACT: begin
        if (elapsed > cfg.still_time) begin
          if (s_r < level_q(cfg.still_upper_level) && s_r > level_q(cfg.recover_level)) begin
            phase_nxt = PH_FALL;
            falls_nxt = falls_r + CNT_W'(1);
          end else begin
            phase_nxt = PH_NORMAL;
          end
        end
      end
      default: phase_nxt = phase_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      primed_r    <= 1'b0;
      s_r         <= '0;
      phase_r     <= PH_NORMAL;
      start_r     <= '0;
      impacts_r   <= '0;
      falls_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == B_SUM) begin
        s_r      <= primed_r ? S_W'(sum >> W_SHIFT) : magq;
        primed_r <= 1'b1;
      end
      if (commit) begin
        phase_r     <= phase_nxt;
        start_r     <= start_nxt;
        impacts_r   <= impacts_nxt;
        falls_r     <= falls_nxt;
        out_valid_r <= 1'b1;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rd_valid && rd_ready) begin
      mag_r   <= rd_item.mag;
      stamp_r <= rd_item.stamp;
      w_r     <= (cfg.ema_weight > W_W'(W_ONE)) ? W_W'(W_ONE) : cfg.ema_weight;
    end
    if (state_r == B_MULA) begin
      prod_a_r <= PROD_W'(w_r * magq);
    end
    if (state_r == B_MULB) begin
      prod_b_r <= PROD_W'((W_W'(W_ONE) - w_r) * s_r);
    end
    if (commit) begin
      out_data_r.pad                <= '0;
      out_data_r.fall_total         <= falls_nxt;
      out_data_r.impact_total       <= impacts_nxt;
      out_data_r.state_changed      <= (phase_nxt != phase_r);
      out_data_r.filtered_magnitude <= OUT_MAG_W'(s_r);
      out_data_r.motion_state       <= phase_nxt;
    end
  end

endmodule

`default_nettype wire

@@ rtl/imu_fall_detector.sv @@
// Each accepted beat is squared and summed axis by axis, its root is formed one bit
// per step, it is pushed into the queue, and the back part multiplies twice, sums and
// decides. The bit-serial root limits the rate: the front takes no new sample until
// it has pushed the last, and the back part none until its result is registered.
// Reset (rst_n low, synchronous) returns the state to normal, clears counters
// and the average, and reloads the configuration registers with their defaults.
`default_nettype none

module imu_fall_detector import ifd_pkg::*; (
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  // tdata: accel_x[15:0], accel_y[31:16], accel_z[47:32], sample_time[79:48]
  input  wire logic                   in_tvalid,
  output logic                        in_tready,
  input  wire logic [IN_TDATA_W-1:0]  in_tdata,
  // tdata: motion_state[1:0], filtered_magnitude[25:2], state_changed[26],
  //        impact_total[42:27], fall_total[58:43], zeros above
  output logic                        out_tvalid,
  input  wire logic                   out_tready,
  output logic [OUT_TDATA_W-1:0]      out_tdata,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_IDX_W-1:0]   cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t      cfg_r;
  logic      push_valid, push_ready;
  mag_item_t push_item;
  logic      q_valid, q_ready;
  mag_item_t q_item;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.ema_weight        <= RST_EMA_WEIGHT;
      cfg_r.free_fall_level   <= RST_FREE_FALL;
      cfg_r.impact_level      <= RST_IMPACT;
      cfg_r.recover_level     <= RST_RECOVER;
      cfg_r.still_upper_level <= RST_STILL_UPPER;
      cfg_r.still_time        <= RST_STILL_TIME;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_idx_t'(cfg_index))
        REG_EMA_WEIGHT:  cfg_r.ema_weight        <= cfg_data[W_W-1:0];
        REG_FREE_FALL:   cfg_r.free_fall_level   <= cfg_data[LEVEL_W-1:0];
        REG_IMPACT:      cfg_r.impact_level      <= cfg_data[LEVEL_W-1:0];
        REG_RECOVER:     cfg_r.recover_level     <= cfg_data[LEVEL_W-1:0];
        REG_STILL_UPPER: cfg_r.still_upper_level <= cfg_data[LEVEL_W-1:0];
        REG_STILL_TIME:  cfg_r.still_time        <= cfg_data[TIME_W-1:0];
        default: ;
      endcase
    end
  end

  ifd_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_item  (push_item)
  );

  ifd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_valid (push_valid),
    .wr_ready (push_ready),
    .wr_item  (push_item),
    .rd_valid (q_valid),
    .rd_ready (q_ready),
    .rd_item  (q_item)
  );

  ifd_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg        (cfg_r),
    .rd_valid   (q_valid),
    .rd_ready   (q_ready),
    .rd_item    (q_item),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

endmodule

`default_nettype wire

@@ rtl/ifd_checker.sv @@
// Port-level checker for the fall detector and the bind that attaches it.
// Uses ifd_pkg for the result beat layout and the motion state codes.
`default_nettype none

module ifd_checker import ifd_pkg::*; (
  input wire logic                   clk,
  input wire logic                   rst_n,
  input wire logic                   out_tvalid,
  input wire logic                   out_tready,
  input wire logic [OUT_TDATA_W-1:0] out_tdata
);

  out_beat_t        beat;
  logic             fire;
  phase_t           prev_state_r;
  logic [CNT_W-1:0] prev_imp_r;
  logic [CNT_W-1:0] prev_fall_r;

  assign beat = out_tdata;
  assign fire = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_state_r <= PH_NORMAL;
      prev_imp_r   <= '0;
      prev_fall_r  <= '0;
    end else if (fire) begin
      prev_state_r <= beat.motion_state;
      prev_imp_r   <= beat.impact_total;
      prev_fall_r  <= beat.fall_total;
    end
  end

  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result beat changed while stalled");

  a_fall_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    fire && prev_state_r == PH_FALL |-> beat.motion_state == PH_FALL)
    else $error("fall detected state was left");

  a_change_flag: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> beat.state_changed == (beat.motion_state != prev_state_r))
    else $error("state change flag disagrees with successive states");

  a_impact_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> beat.impact_total == prev_imp_r
          || (beat.impact_total == prev_imp_r + CNT_W'(1)
              && beat.motion_state == PH_IMPACT && beat.state_changed))
    else $error("impact count moved without entering impact");

  a_fall_step: assert property (@(posedge clk) disable iff (!rst_n)
    fire |-> beat.fall_total == prev_fall_r
          || (beat.fall_total == prev_fall_r + CNT_W'(1)
              && beat.motion_state == PH_FALL && beat.state_changed))
    else $error("fall count moved without detecting a fall");

endmodule

bind imu_fall_detector ifd_checker u_ifd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);

`default_nettype wire

@@ test/imu_fall_detector_test.sv @@
// Self-checking testbench for imu_fall_detector: drives sample beats and register writes,
// predicts every status beat with its own model, and compares the results field by field.
// Depends on ifd_pkg and imu_fall_detector in the rtl folder.
`default_nettype none

module imu_fall_detector_test;
  import ifd_pkg::*;

  localparam int CYCLE_LIMIT      = 1_000_000;
  localparam int SETTLE_CYCLES    = 60;
  localparam int RANDOM_PER_PHASE = 215;
  localparam int EXTREME_ITEMS    = 40;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  imu_fall_detector DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  always #6 clk = ~clk;

  // Predicted detector state and register file.
  cfg_t        pred_cfg;
  phase_t      pred_phase;
  logic [63:0] pred_avg;
  logic        pred_seeded;
  logic [31:0] pred_mark;
  logic [15:0] pred_impacts;
  logic [15:0] pred_falls;

  out_beat_t   expected_status[$];
  logic [31:0] clock_ms = '0;
  int          send_idle_pct = 0;
  int          recv_stall_pct = 0;
  int          mismatch_count = 0;
  int          results_checked = 0;
  int          samples_sent = 0;
  int          settings_used = 1;
  int          cycle_count = 0;

  function automatic logic [31:0] root_floor(input logic [63:0] n);
    logic [63:0] rem;
    logic [63:0] root;
    logic [63:0] bitv;
    rem = n;
    root = '0;
    bitv = 64'd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    return root[31:0];
  endfunction

  function automatic logic [63:0] counts_q(input logic [15:0] lvl);
    return 64'(lvl) << FRAC_BITS;
  endfunction

  function automatic logic [63:0] axis_square(input logic signed [15:0] v);
    longint a;
    a = longint'(v);
    if (a < 0) a = -a;
    return 64'(a * a);
  endfunction

  function automatic out_beat_t predict_status(input in_beat_t b);
    out_beat_t   r;
    logic [63:0] mag_q;
    logic [63:0] w;
    logic [31:0] span;
    phase_t      prior;
    mag_q = 64'(root_floor(axis_square(b.accel_x) + axis_square(b.accel_y) +
                           axis_square(b.accel_z))) << FRAC_BITS;
    w = (pred_cfg.ema_weight > W_ONE) ? 64'(W_ONE) : 64'(pred_cfg.ema_weight);
    if (!pred_seeded) begin
      pred_avg = mag_q;
      pred_seeded = 1'b1;
    end else begin
      pred_avg = (w * mag_q + (64'(W_ONE) - w) * pred_avg + 64'(W_ROUND)) >> W_SHIFT;
    end
    prior = pred_phase;
    span = b.sample_time - pred_mark;
    case (pred_phase)
      PH_NORMAL: begin
        if (pred_avg < counts_q(pred_cfg.free_fall_level)) begin
          pred_phase = PH_FREE_FALL;
          pred_mark = b.sample_time;
        end
      end
      PH_FREE_FALL: begin
        if (pred_avg > counts_q(pred_cfg.impact_level)) begin
          pred_phase = PH_IMPACT;
          pred_mark = b.sample_time;
          pred_impacts = pred_impacts + 16'd1;
        end else if (pred_avg > counts_q(pred_cfg.recover_level)) begin
          pred_phase = PH_NORMAL;
        end
      end
      PH_IMPACT: begin
        if (span > pred_cfg.still_time) begin
          if (pred_avg < counts_q(pred_cfg.still_upper_level) &&
              pred_avg > counts_q(pred_cfg.recover_level)) begin
            pred_phase = PH_FALL;
            pred_falls = pred_falls + 16'd1;
          end else begin
            pred_phase = PH_NORMAL;
          end
        end
      end
      default: ;
    endcase
    r = '0;
    r.motion_state = pred_phase;
    r.filtered_magnitude = pred_avg[OUT_MAG_W-1:0];
    r.state_changed = (pred_phase != prior);
    r.impact_total = pred_impacts;
    r.fall_total = pred_falls;
    return r;
  endfunction

  function automatic in_beat_t pack_sample(input logic [15:0] x, input logic [15:0] y,
                                           input logic [15:0] z, input logic [31:0] t);
    in_beat_t b;
    b.accel_x = x;
    b.accel_y = y;
    b.accel_z = z;
    b.sample_time = t;
    return b;
  endfunction

  // Magnitude mostly along one random axis, with small noise on the others.
  function automatic in_beat_t make_sample(input int mag, input int spread);
    int v[3];
    int ax;
    ax = $urandom_range(0, 2);
    for (int i = 0; i < 3; i++)
      v[i] = (spread == 0) ? 0 : int'($urandom_range(0, 2 * spread)) - spread;
    v[ax] = (mag > 32767) ? 32767 : mag;
    if ($urandom_range(0, 1)) v[ax] = -v[ax];
    return pack_sample(16'(v[0]), 16'(v[1]), 16'(v[2]), clock_ms);
  endfunction

  function automatic logic [15:0] wild_axis();
    case ($urandom_range(0, 9))
      0: return 16'h8000;
      1: return 16'h7FFF;
      2: return 16'h0000;
      3: return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  always @(negedge clk) out_tready <= ($urandom_range(0, 99) >= recv_stall_pct);

  always @(posedge clk) begin
    out_beat_t got;
    out_beat_t want;
    cycle_count = cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding.",
               cycle_count, expected_status.size());
      $display("Regression FAIL");
      $finish;
    end
    if (rst_n && out_tvalid && out_tready) begin
      got = out_beat_t'(out_tdata);
      if (expected_status.size() == 0) begin
        $error("Unexpected status beat %h with no sample outstanding", out_tdata);
        mismatch_count++;
      end else begin
        want = expected_status.pop_front();
        results_checked++;
        if (got.motion_state !== want.motion_state) begin
          $error("motion_state: expected %0d, got %0d", want.motion_state, got.motion_state);
          mismatch_count++;
        end
        if (got.filtered_magnitude !== want.filtered_magnitude) begin
          $error("filtered_magnitude: expected %0d, got %0d",
                 want.filtered_magnitude, got.filtered_magnitude);
          mismatch_count++;
        end
        if (got.state_changed !== want.state_changed) begin
          $error("state_changed: expected %0d, got %0d", want.state_changed, got.state_changed);
          mismatch_count++;
        end
        if (got.impact_total !== want.impact_total) begin
          $error("impact_total: expected %0d, got %0d", want.impact_total, got.impact_total);
          mismatch_count++;
        end
        if (got.fall_total !== want.fall_total) begin
          $error("fall_total: expected %0d, got %0d", want.fall_total, got.fall_total);
          mismatch_count++;
        end
        if (got.pad !== want.pad) begin
          $error("pad: expected %0d, got %0d", want.pad, got.pad);
          mismatch_count++;
        end
      end
    end
  end

  task automatic send_sample(input in_beat_t beat);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      @(negedge clk);
      in_tvalid <= 1'b0;
    end
    @(negedge clk);
    in_tvalid <= 1'b1;
    in_tdata <= IN_TDATA_W'(beat);
    do @(posedge clk); while (in_tready !== 1'b1);
    expected_status.push_back(predict_status(beat));
    samples_sent++;
  endtask

  task automatic settle();
    @(negedge clk);
    in_tvalid <= 1'b0;
    while (expected_status.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (cfg_ready !== 1'b1);
    case (idx)
      REG_EMA_WEIGHT:  pred_cfg.ema_weight = val[W_W-1:0];
      REG_FREE_FALL:   pred_cfg.free_fall_level = val[LEVEL_W-1:0];
      REG_IMPACT:      pred_cfg.impact_level = val[LEVEL_W-1:0];
      REG_RECOVER:     pred_cfg.recover_level = val[LEVEL_W-1:0];
      REG_STILL_UPPER: pred_cfg.still_upper_level = val[LEVEL_W-1:0];
      REG_STILL_TIME:  pred_cfg.still_time = val[TIME_W-1:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic write_settings(input logic [31:0] w, input logic [31:0] ff,
                                input logic [31:0] imp, input logic [31:0] rec,
                                input logic [31:0] up, input logic [31:0] still);
    write_reg(REG_EMA_WEIGHT, w);
    write_reg(REG_FREE_FALL, ff);
    write_reg(REG_IMPACT, imp);
    write_reg(REG_RECOVER, rec);
    write_reg(REG_STILL_UPPER, up);
    write_reg(REG_STILL_TIME, still);
    settings_used++;
  endtask

  task automatic set_idle(input int send_pct, input int recv_pct);
    send_idle_pct = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  // Normal motion, free fall, then either a plain recovery or an impact
  // followed by a stretch of near-still samples.
  task automatic send_fall_attempt();
    int outcome;
    outcome = $urandom_range(0, 3);
    repeat ($urandom_range(1, 6)) begin
      clock_ms = clock_ms + $urandom_range(5, 40);
      send_sample(make_sample($urandom_range(900, 1100), 60));
    end
    repeat ($urandom_range(2, 14)) begin
      clock_ms = clock_ms + $urandom_range(5, 40);
      send_sample(make_sample($urandom_range(0, 300), 40));
    end
    if (outcome == 0) begin
      repeat ($urandom_range(2, 8)) begin
        clock_ms = clock_ms + $urandom_range(5, 40);
        send_sample(make_sample($urandom_range(900, 1100), 60));
      end
    end else begin
      repeat ($urandom_range(1, 4)) begin
        clock_ms = clock_ms + $urandom_range(1, 30);
        send_sample(make_sample($urandom_range(2500, 32767), 200));
      end
      repeat ($urandom_range(2, 10)) begin
        clock_ms = clock_ms + $urandom_range(20, 600);
        send_sample(make_sample($urandom_range(700, 1300), 50));
      end
    end
  endtask

  task automatic send_noise_burst();
    repeat ($urandom_range(1, 5)) begin
      clock_ms = $urandom;
      send_sample(pack_sample(wild_axis(), wild_axis(), wild_axis(), clock_ms));
    end
  endtask

  task automatic send_mixed_traffic(input int count);
    int start;
    start = samples_sent;
    while (samples_sent - start < count) begin
      if ($urandom_range(0, 99) < 75) send_fall_attempt();
      else send_noise_burst();
    end
  endtask

  // Reset values: seeding by the first sample, extreme axes, the impact
  // still-time boundary, timestamp wrap and a return to steady samples.
  task automatic test_reset_defaults();
    set_idle(0, 0);
    send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000, 32'd0));
    send_sample(pack_sample(16'h0000, 16'h0000, 16'h0000, 32'd10));
    send_sample(pack_sample(16'h8000, 16'h8000, 16'h8000, 32'd20));
    send_sample(pack_sample(16'h7FFF, 16'h7FFF, 16'h7FFF, 32'd20));
    send_sample(pack_sample(16'h7FFF, 16'h8000, 16'h0000, 32'd1020));
    send_sample(pack_sample(16'h8000, 16'h7FFF, 16'hFFFF, 32'd1021));
    for (int i = 0; i < 12; i++)
      send_sample(pack_sample(16'h0001, 16'hFFFF, 16'h0001, 32'hFFFF_FFFA + 32'(i)));
    for (int i = 0; i < 6; i++)
      send_sample(pack_sample(16'd1000, 16'h0000, 16'h0000, 32'd40 + 32'(i)));
    settle();
  endtask

  // Register extremes, weight saturation and writes to unused indexes.
  // The still band is kept empty so that the latched fall state is not reached.
  task automatic test_register_extremes();
    clock_ms = $urandom;
    set_idle(35, 35);
    write_settings(32'd0, 32'd65535, 32'd0, 32'd65535, 32'd65535, 32'd0);
    send_mixed_traffic(EXTREME_ITEMS);
    settle();
    set_idle(0, 0);
    write_settings(32'd256, 32'd0, 32'd65535, 32'd0, 32'd0, 32'hFFFF_FFFF);
    write_reg(REG_SPARE_LO, $urandom);
    send_mixed_traffic(EXTREME_ITEMS);
    settle();
    set_idle(79, 0);
    write_settings(32'd511, 32'd1000, 32'd2000, 32'd1500, 32'd1500, 32'd1);
    write_reg(REG_SPARE_HI, $urandom);
    send_mixed_traffic(EXTREME_ITEMS);
    settle();
    set_idle(0, 79);
    write_settings(32'd300, 32'd700, 32'd1500, 32'd900, 32'd400, 32'd200);
    send_mixed_traffic(EXTREME_ITEMS);
    settle();
  endtask

  task automatic test_random_traffic();
    logic [31:0] rec;
    for (int mode = 0; mode < 8; mode++) begin
      case (mode % 4)
        0: set_idle(0, 0);
        1: set_idle(79, 0);
        2: set_idle(0, 79);
        default: set_idle(35, 35);
      endcase
      rec = $urandom_range(400, 1600);
      write_settings(($urandom_range(0, 9) == 0) ? $urandom_range(257, 511)
                                                 : $urandom_range(30, 256),
                     $urandom_range(150, 900), $urandom_range(1500, 8000), rec,
                     $urandom_range(0, rec), $urandom_range(0, 1500));
      send_mixed_traffic(RANDOM_PER_PHASE);
      settle();
    end
  endtask

  // Drives a clean fall sequence until the state latches, then checks that it holds.
  task automatic test_fall_latch();
    set_idle(35, 35);
    write_settings(32'd256, 32'(RST_FREE_FALL), 32'(RST_IMPACT), 32'(RST_RECOVER),
                   32'(RST_STILL_UPPER), RST_STILL_TIME);
    for (int k = 0; k < 6 && pred_phase != PH_FALL; k++) begin
      clock_ms = clock_ms + 50;
      send_sample(make_sample(1000, 0));
      clock_ms = clock_ms + 20;
      send_sample(make_sample(100, 0));
      clock_ms = clock_ms + 20;
      send_sample(make_sample(5000, 0));
      clock_ms = clock_ms + 500;
      send_sample(make_sample(1000, 0));
      clock_ms = clock_ms + 600;
      send_sample(make_sample(1000, 0));
    end
    send_mixed_traffic(30);
    settle();
  endtask

  initial begin
    pred_cfg.ema_weight = RST_EMA_WEIGHT;
    pred_cfg.free_fall_level = RST_FREE_FALL;
    pred_cfg.impact_level = RST_IMPACT;
    pred_cfg.recover_level = RST_RECOVER;
    pred_cfg.still_upper_level = RST_STILL_UPPER;
    pred_cfg.still_time = RST_STILL_TIME;
    pred_phase = PH_NORMAL;
    pred_avg = '0;
    pred_seeded = 1'b0;
    pred_mark = '0;
    pred_impacts = '0;
    pred_falls = '0;
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_defaults();
    test_register_extremes();
    test_random_traffic();
    test_fall_latch();
    $display("Checked %0d status beats from %0d samples over %0d register settings.",
             results_checked, samples_sent, settings_used);
    $display("Flow control varied on both sides; %0d impacts and %0d falls, ending in %s.",
             pred_impacts, pred_falls, pred_phase.name());
    if (mismatch_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire

@@ sim.f @@
rtl/ifd_pkg.sv
rtl/ifd_front.sv
rtl/ifd_fifo.sv
rtl/ifd_back.sv
rtl/imu_fall_detector.sv
rtl/ifd_checker.sv
test/imu_fall_detector_test.sv
